/* sv/pressure_sensor_compensation_unit_defines.svh */
// ---------------------------------------------------------------------------
// Pressure sensor compensation unit: assertion macros
// Shared property forms for the checker of the compensation pipeline.
// ---------------------------------------------------------------------------
`ifndef PRESSURE_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held
`define PSCU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pscu: same-cycle check failed");

// Next-cycle implication, switched off while reset is held
`define PSCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pscu: next-cycle check failed");

`endif

/* sv/pscu_pkg.sv */
// ---------------------------------------------------------------------------
// Pressure sensor compensation unit: shared package
// Field widths, compensation constants, register indexes and the structs
// that travel between the pipeline sections.
// ---------------------------------------------------------------------------
package pscu_pkg;

    // Port field widths
    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int TEMP_W    = 19;
    localparam int PRESS_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Compensation constants (hundredths of a degree and shift counts)
    localparam int TEMP_REF        = 2000;
    localparam int TEMP_COLD       = -1500;
    localparam int TEMP_HOT        = 4500;
    localparam int REF_TEMP_SHIFT  = 8;
    localparam int TEMP_SHIFT      = 23;
    localparam int OFF_SHIFT       = 7;
    localparam int SENS_SHIFT      = 8;
    localparam int OFF_BASE_SHIFT  = 16;
    localparam int SENS_BASE_SHIFT = 15;
    localparam int T2_SHIFT        = 31;
    localparam int PRESS_SHIFT1    = 21;
    localparam int PRESS_SHIFT2    = 15;

    // Internal widths, sized to the value ranges
    localparam int DT_W       = RAW_W + 1;
    localparam int PROD_W     = DT_W + COEF_W + 1;
    localparam int DTSQ_W     = 2 * DT_W;
    localparam int T2_W       = 17;
    localparam int OFF_W      = PROD_W - OFF_SHIFT;
    localparam int SENS_W     = PROD_W - SENS_SHIFT;
    localparam int DEV_SQ_W   = 34;
    localparam int OFF2_W     = DEV_SQ_W + 2;
    localparam int SENS2_W    = DEV_SQ_W + 2;
    localparam int OFF_F_W    = 37;
    localparam int SENS_F_W   = 38;
    localparam int SPLIT_W    = 19;
    localparam int PL_W       = RAW_W + SPLIT_W;
    localparam int PH_W       = RAW_W + 1 + SENS_F_W - SPLIT_W;
    localparam int HI_W       = PH_W + 1;
    localparam int SHIFTED_W  = HI_W - (PRESS_SHIFT1 - SPLIT_W);

    // Register stages from input to output
    localparam int PIPE_DEPTH = 7;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS          = 3'd0,
        REG_OFFSET        = 3'd1,
        REG_SENS_TEMPCO   = 3'd2,
        REG_OFFSET_TEMPCO = 3'd3,
        REG_REF_TEMP      = 3'd4,
        REG_TEMP_SLOPE    = 3'd5
    } cfg_reg_t;

    // Calibration words
    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] offset;
        logic [COEF_W-1:0] sens_tempco;
        logic [COEF_W-1:0] offset_tempco;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_slope;
    } cfg_t;

    // First-order results
    typedef struct packed {
        logic        [RAW_W-1:0]  d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic        [T2_W-1:0]   t2;
    } first_t;

    // Second-order corrected results
    typedef struct packed {
        logic        [RAW_W-1:0]    d1;
        logic signed [TEMP_W-1:0]   temp;
        logic signed [OFF_F_W-1:0]  off;
        logic signed [SENS_F_W-1:0] sens;
    } second_t;

endpackage

/* sv/pscu_first_order.sv */
// ---------------------------------------------------------------------------
// Pressure sensor compensation unit: first-order section
// Three stages: temperature difference, coefficient products, first-order
// temperature, offset and sensitivity.
// ---------------------------------------------------------------------------
module pscu_first_order (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pscu_pkg::cfg_t            cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [pscu_pkg::RAW_W-1:0] raw_pressure,
    input  logic [pscu_pkg::RAW_W-1:0] raw_temperature,
    output logic                      out_valid,
    input  logic                      out_ready,
    output pscu_pkg::first_t          out_data
);
    import pscu_pkg::*;

    logic                     s1_valid_reg;
    logic [RAW_W-1:0]         s1_d1_reg;
    logic signed [DT_W-1:0]   s1_dt_reg;
    logic signed [DT_W-1:0]   dt_next;

    logic                     s2_valid_reg;
    logic [RAW_W-1:0]         s2_d1_reg;
    logic signed [TEMP_W-1:0] s2_tcorr_reg;
    logic signed [OFF_W-1:0]  s2_offcorr_reg;
    logic signed [SENS_W-1:0] s2_senscorr_reg;
    logic [T2_W-1:0]          s2_t2_reg;
    logic signed [PROD_W-1:0] tprod;
    logic signed [PROD_W-1:0] offprod;
    logic signed [PROD_W-1:0] sensprod;
    logic signed [DTSQ_W-1:0] dtsq;

    logic                     s3_valid_reg;
    first_t                   s3_data_reg;
    first_t                   s3_data_next;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    // Stage readiness: a stage takes a request when empty or when it drains
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Temperature difference from the reference word
    assign dt_next = $signed({1'b0, raw_temperature})
                   - $signed({1'b0, cfg.ref_temp, {REF_TEMP_SHIFT{1'b0}}});

    // Coefficient products
    assign tprod    = s1_dt_reg * $signed({1'b0, cfg.temp_slope});
    assign offprod  = s1_dt_reg * $signed({1'b0, cfg.offset_tempco});
    assign sensprod = s1_dt_reg * $signed({1'b0, cfg.sens_tempco});
    assign dtsq     = s1_dt_reg * s1_dt_reg;

    // First-order sums
    always_comb
    begin
        s3_data_next.d1   = s2_d1_reg;
        s3_data_next.temp = TEMP_W'(TEMP_REF) + s2_tcorr_reg;
        s3_data_next.off  = $signed({{(OFF_W - COEF_W - OFF_BASE_SHIFT){1'b0}},
                                     cfg.offset, {OFF_BASE_SHIFT{1'b0}}})
                          + s2_offcorr_reg;
        s3_data_next.sens = $signed({{(SENS_W - COEF_W - SENS_BASE_SHIFT){1'b0}},
                                     cfg.sens, {SENS_BASE_SHIFT{1'b0}}})
                          + s2_senscorr_reg;
        s3_data_next.t2   = s2_t2_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_d1_reg <= raw_pressure;
            s1_dt_reg <= dt_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_d1_reg       <= s1_d1_reg;
            s2_tcorr_reg    <= tprod[PROD_W-1:TEMP_SHIFT];
            s2_offcorr_reg  <= offprod[PROD_W-1:OFF_SHIFT];
            s2_senscorr_reg <= sensprod[PROD_W-1:SENS_SHIFT];
            s2_t2_reg       <= dtsq[T2_SHIFT+T2_W-1:T2_SHIFT];
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

/* sv/pscu_second_order.sv */
// ---------------------------------------------------------------------------
// Pressure sensor compensation unit: second-order section
// Two stages: deviation squares and range flags, then the cold corrections to
// temperature, offset and sensitivity or the hot correction to sensitivity.
// ---------------------------------------------------------------------------
module pscu_second_order (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pscu_pkg::first_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pscu_pkg::second_t out_data
);
    import pscu_pkg::*;

    logic                       s4_valid_reg;
    first_t                     s4_data_reg;
    logic                       s4_cold_reg;
    logic                       s4_vcold_reg;
    logic                       s4_hot_reg;
    logic [DEV_SQ_W-1:0]        s4_sqa_reg;
    logic [DEV_SQ_W-1:0]        s4_sqb_reg;

    logic                       cold;
    logic                       vcold;
    logic                       hot;
    logic signed [TEMP_W-1:0]   dev_a;
    logic signed [TEMP_W-1:0]   dev_b;
    logic signed [2*TEMP_W-1:0] sq_a;
    logic signed [2*TEMP_W-1:0] sq_b;

    logic                       s5_valid_reg;
    second_t                    s5_data_reg;
    second_t                    s5_data_next;

    logic [OFF2_W-1:0]          off2;
    logic [DEV_SQ_W+2:0]        seven_sq;
    logic [SENS2_W-1:0]         sens2_cold;
    logic [DEV_SQ_W-4:0]        sens2_hot;

    logic s4_ready;
    logic s5_ready;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    // Range flags and deviations from the break points
    assign cold  = in_data.temp < TEMP_W'(TEMP_REF);
    assign vcold = in_data.temp < TEMP_W'(TEMP_COLD);
    assign hot   = in_data.temp >= TEMP_W'(TEMP_HOT);
    assign dev_a = cold ? (in_data.temp - TEMP_W'(TEMP_REF))
                        : (in_data.temp - TEMP_W'(TEMP_HOT));
    assign dev_b = in_data.temp - TEMP_W'(TEMP_COLD);
    assign sq_a  = dev_a * dev_a;
    assign sq_b  = dev_b * dev_b;

    // Offset and sensitivity corrections
    assign off2       = OFF2_W'({s4_sqa_reg, 1'b0}) + OFF2_W'(s4_sqa_reg);
    assign seven_sq   = {s4_sqa_reg, 3'b000} - {3'b000, s4_sqa_reg};
    assign sens2_cold = SENS2_W'(seven_sq[DEV_SQ_W+2:3])
                      + (s4_vcold_reg ? SENS2_W'({s4_sqb_reg, 1'b0}) : SENS2_W'(0));
    assign sens2_hot  = s4_sqa_reg[DEV_SQ_W-1:3];

    // Apply the corrections for the temperature band
    always_comb
    begin
        s5_data_next.d1   = s4_data_reg.d1;
        s5_data_next.temp = s4_data_reg.temp;
        s5_data_next.off  = OFF_F_W'(s4_data_reg.off);
        s5_data_next.sens = SENS_F_W'(s4_data_reg.sens);
        if (s4_cold_reg)
        begin
            s5_data_next.temp = s4_data_reg.temp - TEMP_W'(s4_data_reg.t2);
            s5_data_next.off  = OFF_F_W'(s4_data_reg.off) - OFF_F_W'(off2);
            s5_data_next.sens = SENS_F_W'(s4_data_reg.sens) - SENS_F_W'(sens2_cold);
        end
        else if (s4_hot_reg)
        begin
            s5_data_next.sens = SENS_F_W'(s4_data_reg.sens) + SENS_F_W'(sens2_hot);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
            begin
                s4_valid_reg <= in_valid;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (s4_ready && in_valid)
        begin
            s4_data_reg  <= in_data;
            s4_cold_reg  <= cold;
            s4_vcold_reg <= vcold;
            s4_hot_reg   <= hot;
            s4_sqa_reg   <= sq_a[DEV_SQ_W-1:0];
            s4_sqb_reg   <= sq_b[DEV_SQ_W-1:0];
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_data_reg <= s5_data_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

endmodule

/* sv/pscu_pressure.sv */
// ---------------------------------------------------------------------------
// Pressure sensor compensation unit: pressure section
// Two stages: split product of raw pressure and sensitivity, then
// recombination, offset removal and final scaling into the output register.
// ---------------------------------------------------------------------------
module pscu_pressure (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  pscu_pkg::second_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pscu_pkg::TEMP_W-1:0]  temperature_centi,
    output logic signed [pscu_pkg::PRESS_W-1:0] pressure_comp
);
    import pscu_pkg::*;

    logic                          s6_valid_reg;
    logic signed [TEMP_W-1:0]      s6_temp_reg;
    logic signed [OFF_F_W-1:0]     s6_off_reg;
    logic [PL_W-1:0]               s6_pl_reg;
    logic signed [PH_W-1:0]        s6_ph_reg;

    logic [SPLIT_W-1:0]            sens_lo;
    logic signed [SENS_F_W-SPLIT_W-1:0] sens_hi;
    logic [PL_W-1:0]               pl;
    logic signed [PH_W-1:0]        ph;

    logic                          s7_valid_reg;
    logic signed [TEMP_W-1:0]      s7_temp_reg;
    logic signed [PRESS_W-1:0]     s7_press_reg;

    logic signed [HI_W-1:0]        hi_sum;
    logic signed [SHIFTED_W-1:0]   diff;
    logic signed [PRESS_W-1:0]     press_next;

    logic s6_ready;
    logic s7_ready;

    assign s7_ready = !s7_valid_reg || out_ready;
    assign s6_ready = !s6_valid_reg || s7_ready;
    assign in_ready = s6_ready;

    // Split sensitivity into an unsigned low part and a signed high part
    assign sens_lo = in_data.sens[SPLIT_W-1:0];
    assign sens_hi = in_data.sens[SENS_F_W-1:SPLIT_W];
    assign pl      = in_data.d1 * sens_lo;
    assign ph      = $signed({1'b0, in_data.d1}) * sens_hi;

    // Recombine above the low split; the bits below it cannot reach the shifted result
    assign hi_sum = HI_W'(s6_ph_reg) + HI_W'(s6_pl_reg[PL_W-1:SPLIT_W]);
    assign diff   = $signed(hi_sum[HI_W-1:PRESS_SHIFT1-SPLIT_W]) - SHIFTED_W'(s6_off_reg);

    // The scaled result spans fewer bits than the output, so sign-extend
    assign press_next = PRESS_W'($signed(diff[SHIFTED_W-1:PRESS_SHIFT2]));

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (s6_ready)
            begin
                s6_valid_reg <= in_valid;
            end
            if (s7_ready)
            begin
                s7_valid_reg <= s6_valid_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (s6_ready && in_valid)
        begin
            s6_temp_reg <= in_data.temp;
            s6_off_reg  <= in_data.off;
            s6_pl_reg   <= pl;
            s6_ph_reg   <= ph;
        end
        if (s7_ready && s6_valid_reg)
        begin
            s7_temp_reg  <= s6_temp_reg;
            s7_press_reg <= press_next;
        end
    end

    assign out_valid         = s7_valid_reg;
    assign temperature_centi = s7_temp_reg;
    assign pressure_comp     = s7_press_reg;

endmodule

/* sv/pressure_sensor_compensation_unit.sv */
// Seven register stages carry a request to the output, with multiplies in stages two, four and six.
// Throughput: one request per cycle while the output is not stalled.
// A stalled output holds its result while empty stages behind it keep taking requests.
// Reset (rst_n low, asynchronous) clears all valid bits and the calibration words.
// Calibration words are written one per cycle through the write port.
// ---------------------------------------------------------------------------
// Pressure sensor compensation unit: top level
// Holds the six calibration words and chains the first-order, second-order
// and pressure sections of the compensation pipeline.
// ---------------------------------------------------------------------------
module pressure_sensor_compensation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pscu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pscu_pkg::COEF_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pscu_pkg::RAW_W-1:0]          raw_pressure,
    input  logic [pscu_pkg::RAW_W-1:0]          raw_temperature,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pscu_pkg::TEMP_W-1:0]  temperature_centi,
    output logic signed [pscu_pkg::PRESS_W-1:0] pressure_comp
);
    import pscu_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;

    logic    first_ready;
    logic    first_valid;
    first_t  first_data;
    logic    second_ready;
    logic    second_valid;
    second_t second_data;
    logic    press_ready;

    // Decode calibration writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SENS:          cfg_next.sens          = cfg_data;
                REG_OFFSET:        cfg_next.offset        = cfg_data;
                REG_SENS_TEMPCO:   cfg_next.sens_tempco   = cfg_data;
                REG_OFFSET_TEMPCO: cfg_next.offset_tempco = cfg_data;
                REG_REF_TEMP:      cfg_next.ref_temp      = cfg_data;
                REG_TEMP_SLOPE:    cfg_next.temp_slope    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold calibration words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pscu_first_order u_first (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (first_ready),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .out_valid       (first_valid),
        .out_ready       (second_ready),
        .out_data        (first_data)
    );

    pscu_second_order u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (first_valid),
        .in_ready  (second_ready),
        .in_data   (first_data),
        .out_valid (second_valid),
        .out_ready (press_ready),
        .out_data  (second_data)
    );

    pscu_pressure u_press (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (second_valid),
        .in_ready          (press_ready),
        .in_data           (second_data),
        .out_valid         (out_valid),
        .out_ready         (!out_stall),
        .temperature_centi (temperature_centi),
        .pressure_comp     (pressure_comp)
    );

    assign in_stall = !first_ready;

endmodule

/* sv/pscu_checker.sv */
// ---------------------------------------------------------------------------
// Pressure sensor compensation unit: port checker
// Watches the top-level ports for result holding, input back-pressure and
// pipeline latency; bound to the top level below.
// ---------------------------------------------------------------------------
`include "pressure_sensor_compensation_unit_defines.svh"

module pscu_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [pscu_pkg::TEMP_W-1:0]  temperature_centi,
    input logic signed [pscu_pkg::PRESS_W-1:0] pressure_comp
);
    import pscu_pkg::*;

    logic in_take;
    logic out_held;

    // Handshake outcomes on each side
    assign in_take  = in_valid && !in_stall;
    assign out_held = out_valid && out_stall;

    // A stalled result stays presented
    `PSCU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid)

    // A stalled result keeps its value
    `PSCU_ASSERT_NEXT(a_out_stable, clk, rst_n, out_held, $stable(temperature_centi) && $stable(pressure_comp))

    // With the output register empty the input never stalls
    `PSCU_ASSERT_SAME(a_no_false_stall, clk, rst_n, !out_valid, !in_stall)

    // A result appearing on an empty output must trace back to a request taken at the input
    `PSCU_ASSERT_SAME(a_latency, clk, rst_n, $rose(out_valid), $past(in_take, PIPE_DEPTH))

endmodule

bind pressure_sensor_compensation_unit pscu_checker u_pscu_checker (.*);

/* sim/pressure_sensor_compensation_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pressure sensor compensation unit: testbench
// Loads sets of calibration words, feeds raw pressure and temperature
// conversion pairs and checks every compensated reading against a local
// predictor of the first- and second-order arithmetic. A short table of
// directed requests covers reset values, coefficient extremes and the
// branch edges of the correction; random phases follow, with random gaps
// on the request side and random back-pressure on the result side.
// ---------------------------------------------------------------------------
module pressure_sensor_compensation_unit_tb;

    import pscu_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_CYCLES     = 120;
    localparam int BURST_ITEMS     = 40;
    localparam int PRINT_LIMIT     = 50;
    localparam int PROBE_COUNT     = 24;

    localparam longint PRESS_MAX = 64'sd2147483647;
    localparam longint PRESS_MIN = -64'sd2147483648;

    // Write addresses that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    typedef enum logic [2:0] {
        CAL_RESET,
        CAL_TYPICAL,
        CAL_FULL,
        CAL_COLD,
        CAL_HOT
    } cal_preset_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  temp;
        logic signed [PRESS_W-1:0] press;
    } reading_t;

    typedef struct packed {
        cal_preset_t               cal_sel;
        logic [RAW_W-1:0]          d1;
        logic [RAW_W-1:0]          d2;
        logic                      known;
        logic signed [TEMP_W-1:0]  t_want;
        logic signed [PRESS_W-1:0] p_want;
    } probe_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [COEF_W-1:0]           cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [RAW_W-1:0]            raw_pressure = '0;
    logic [RAW_W-1:0]            raw_temperature = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [TEMP_W-1:0]    temperature_centi;
    logic signed [PRESS_W-1:0]   pressure_comp;

    cfg_t     cal_words = '0;
    reading_t pending_readings [$];
    int       fault_count = 0;
    bit       quiet_traffic = 1'b0;
    int       hold_epoch = 0;

    // With all words at zero the reading is 20.00 C and zero pressure
    probe_t probe_table [0:PROBE_COUNT-1] = '{
        '{CAL_RESET,   24'h000000,  24'h000000,  1'b1, 19'sd2000, 32'sd0},
        '{CAL_RESET,   24'hFFFFFF,  24'hFFFFFF,  1'b1, 19'sd2000, 32'sd0},
        '{CAL_RESET,   24'hFFFFFF,  24'h000000,  1'b1, 19'sd2000, 32'sd0},
        '{CAL_RESET,   24'h000000,  24'hFFFFFF,  1'b1, 19'sd2000, 32'sd0},
        '{CAL_RESET,   24'hA5A5A5,  24'h5A5A5A,  1'b1, 19'sd2000, 32'sd0},
        // dT of zero, then either side of 20.00 C, 45.00 C and -15.00 C
        '{CAL_TYPICAL, 24'd9085466, 24'd8077568, 1'b0, '0, '0},
        '{CAL_TYPICAL, 24'd9085466, 24'd8077567, 1'b0, '0, '0},
        '{CAL_TYPICAL, 24'd9085466, 24'd8822164, 1'b0, '0, '0},
        '{CAL_TYPICAL, 24'd9085466, 24'd8822163, 1'b0, '0, '0},
        '{CAL_TYPICAL, 24'd9085466, 24'd7035135, 1'b0, '0, '0},
        '{CAL_TYPICAL, 24'd9085466, 24'd7035134, 1'b0, '0, '0},
        '{CAL_TYPICAL, 24'h000000,  24'h000000,  1'b0, '0, '0},
        '{CAL_TYPICAL, 24'hFFFFFF,  24'hFFFFFF,  1'b0, '0, '0},
        '{CAL_FULL,    24'h000000,  24'h000000,  1'b0, '0, '0},
        '{CAL_FULL,    24'hFFFFFF,  24'h000000,  1'b0, '0, '0},
        '{CAL_FULL,    24'hFFFFFF,  24'hFFFFFF,  1'b0, '0, '0},
        '{CAL_FULL,    24'h000000,  24'hFFFFFF,  1'b0, '0, '0},
        // Coldest reachable temperature; negative pressure at full raw pressure
        '{CAL_COLD,    24'hFFFFFF,  24'h000000,  1'b0, '0, '0},
        '{CAL_COLD,    24'h000000,  24'h000000,  1'b0, '0, '0},
        '{CAL_COLD,    24'h800000,  24'h400000,  1'b0, '0, '0},
        // Hottest reachable temperature
        '{CAL_HOT,     24'hFFFFFF,  24'hFFFFFF,  1'b0, '0, '0},
        '{CAL_HOT,     24'h000000,  24'hFFFFFF,  1'b0, '0, '0},
        '{CAL_HOT,     24'h123456,  24'hF00000,  1'b0, '0, '0},
        // Zeros written back must behave like reset
        '{CAL_RESET,   24'hFFFFFF,  24'h800000,  1'b1, 19'sd2000, 32'sd0}
    };

    pressure_sensor_compensation_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .raw_pressure      (raw_pressure),
        .raw_temperature   (raw_temperature),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .temperature_centi (temperature_centi),
        .pressure_comp     (pressure_comp)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Compensated reading for one conversion pair under the current words
    function automatic reading_t compensate_reading(input logic [RAW_W-1:0] d1_raw,
                                                    input logic [RAW_W-1:0] d2_raw);
        longint   k_sens, k_off, k_sens_tc, k_off_tc, k_ref, k_slope;
        longint   d1, dt, temp_c, off, sens, t2, off2, sens2, dev, press;
        reading_t r;
        k_sens    = cal_words.sens;
        k_off     = cal_words.offset;
        k_sens_tc = cal_words.sens_tempco;
        k_off_tc  = cal_words.offset_tempco;
        k_ref     = cal_words.ref_temp;
        k_slope   = cal_words.temp_slope;
        d1        = d1_raw;
        dt        = d2_raw;

        // First order
        dt     = dt - (k_ref <<< REF_TEMP_SHIFT);
        temp_c = TEMP_REF + ((dt * k_slope) >>> TEMP_SHIFT);
        off    = (k_off <<< OFF_BASE_SHIFT) + ((k_off_tc * dt) >>> OFF_SHIFT);
        sens   = (k_sens <<< SENS_BASE_SHIFT) + ((k_sens_tc * dt) >>> SENS_SHIFT);

        // Second order: cold corrections, or the hot sensitivity term
        if (temp_c < TEMP_REF)
        begin
            dev   = temp_c - TEMP_REF;
            t2    = (dt * dt) >>> T2_SHIFT;
            off2  = 3 * dev * dev;
            sens2 = (7 * dev * dev) >>> 3;
            if (temp_c < TEMP_COLD)
            begin
                dev   = temp_c - TEMP_COLD;
                sens2 = sens2 + 2 * dev * dev;
            end
        end
        else
        begin
            t2    = 0;
            off2  = 0;
            sens2 = 0;
            if (temp_c >= TEMP_HOT)
            begin
                dev   = temp_c - TEMP_HOT;
                sens2 = sens2 - ((dev * dev) >>> 3);
            end
        end

        temp_c = temp_c - t2;
        off    = off - off2;
        sens   = sens - sens2;
        press  = (((d1 * sens) >>> PRESS_SHIFT1) - off) >>> PRESS_SHIFT2;
        if (press > PRESS_MAX)
            press = PRESS_MAX;
        if (press < PRESS_MIN)
            press = PRESS_MIN;

        r.temp  = temp_c[TEMP_W-1:0];
        r.press = press[PRESS_W-1:0];
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_traffic || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COEF_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return COEF_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return RAW_W'($urandom_range(0, 24'hFFFFFF));
    endfunction

    // Bias a third of the temperatures towards the reference so that
    // the edges at 20, -15 and 45 degrees are crossed often
    function automatic logic [RAW_W-1:0] pick_temperature_raw();
        longint centre, v;
        int     offs;
        if ($urandom_range(0, 2) != 0)
            return pick_raw();
        centre = cal_words.ref_temp;
        centre = centre <<< REF_TEMP_SHIFT;
        offs   = $urandom_range(0, 4194304);
        v      = centre + offs - 2097152;
        if (v < 0)
            v = 0;
        if (v > 16777215)
            v = 16777215;
        return v[RAW_W-1:0];
    endfunction

    task automatic report_fault(input string msg);
        if (fault_count < PRINT_LIMIT)
            $display("[%0t] %s", $time, msg);
        fault_count++;
    endtask

    // One register write; the local copy follows the address decode
    task automatic write_cal_word(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COEF_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SENS:          cal_words.sens          = val;
            REG_OFFSET:        cal_words.offset        = val;
            REG_SENS_TEMPCO:   cal_words.sens_tempco   = val;
            REG_OFFSET_TEMPCO: cal_words.offset_tempco = val;
            REG_REF_TEMP:      cal_words.ref_temp      = val;
            REG_TEMP_SLOPE:    cal_words.temp_slope    = val;
            default:           ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Load all six words, then a stray write that must be dropped
    task automatic load_calibration(input cfg_t words);
        write_cal_word(REG_SENS,          words.sens);
        write_cal_word(REG_OFFSET,        words.offset);
        write_cal_word(REG_SENS_TEMPCO,   words.sens_tempco);
        write_cal_word(REG_OFFSET_TEMPCO, words.offset_tempco);
        write_cal_word(REG_REF_TEMP,      words.ref_temp);
        write_cal_word(REG_TEMP_SLOPE,    words.temp_slope);
        write_cal_word($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                       pick_word());
    endtask

    // Present one request and hold it until taken; returns on the taking edge
    task automatic offer_conversion(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                                    input reading_t want, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_pressure    <= d1;
        raw_temperature <= d2;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_readings.push_back(want);
    endtask

    // Drop valid and let the pipeline empty before touching the words
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Result side: check each taken reading, then choose the next stall
    initial
    begin
        reading_t want;
        int       stall_left;
        int       hold_left;
        int       seen_epoch;
        int       r;
        stall_left = 0;
        hold_left  = 0;
        seen_epoch = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_readings.size() == 0)
                begin
                    report_fault($sformatf("reading with nothing outstanding: temp %0d press %0d",
                                           temperature_centi, pressure_comp));
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (temperature_centi !== want.temp)
                        report_fault($sformatf("temperature_centi: got %0d, want %0d",
                                               temperature_centi, want.temp));
                    if (pressure_comp !== want.press)
                        report_fault($sformatf("pressure_comp: got %0d, want %0d",
                                               pressure_comp, want.press));
                end
            end

            if (seen_epoch != hold_epoch)
            begin
                seen_epoch = hold_epoch;
                hold_left  = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_traffic && $urandom_range(0, 99) < 20)
            begin
                r          = $urandom_range(0, 99);
                stall_left = (r < 85) ? $urandom_range(0, 2) : $urandom_range(7, 39);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pressure_sensor_compensation_unit_tb NOT OK");
        $finish;
    end

    // Stimulus
    initial
    begin
        cfg_t             words;
        cal_preset_t      loaded;
        reading_t         want;
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;
        loaded = CAL_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < PROBE_COUNT; i++)
        begin
            if (probe_table[i].cal_sel != loaded)
            begin
                wait_until_drained();
                case (probe_table[i].cal_sel)
                    CAL_TYPICAL: words = '{16'd46372, 16'd43981, 16'd29059,
                                           16'd27842, 16'd31553, 16'd28165};
                    CAL_FULL:    words = '1;
                    CAL_COLD:    words = '{16'h0000, 16'h0000, 16'h0000,
                                           16'h0000, 16'hFFFF, 16'hFFFF};
                    CAL_HOT:     words = '{16'hFFFF, 16'hFFFF, 16'hFFFF,
                                           16'hFFFF, 16'h0000, 16'hFFFF};
                    default:     words = '0;
                endcase
                load_calibration(words);
                loaded = probe_table[i].cal_sel;
            end
            if (probe_table[i].known)
                want = '{probe_table[i].t_want, probe_table[i].p_want};
            else
                want = compensate_reading(probe_table[i].d1, probe_table[i].d2);
            offer_conversion(probe_table[i].d1, probe_table[i].d2, want, 1'b0);
        end

        // Random phases, each under fresh calibration words
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_until_drained();
            words = '{pick_word(), pick_word(), pick_word(),
                      pick_word(), pick_word(), pick_word()};
            load_calibration(words);
            quiet_traffic = (ph == 0);
            if (ph == HOLD_PHASE)
                hold_epoch++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                d1 = pick_raw();
                d2 = pick_temperature_raw();
                offer_conversion(d1, d2, compensate_reading(d1, d2),
                                 ph == HOLD_PHASE && n < BURST_ITEMS);
            end
        end

        // Flush and allow for anything extra the block might emit
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (4 * PIPE_DEPTH) @(posedge clk);

        if (fault_count == 0)
            $display("pressure_sensor_compensation_unit_tb OK");
        else
            $display("pressure_sensor_compensation_unit_tb NOT OK");
        $finish;
    end

endmodule

/* pressure_sensor_compensation_unit.f */
+incdir+sv
sv/pscu_pkg.sv
sv/pscu_first_order.sv
sv/pscu_second_order.sv
sv/pscu_pressure.sv
sv/pressure_sensor_compensation_unit.sv
sv/pscu_checker.sv
sim/pressure_sensor_compensation_unit_tb.sv
